/* design/absu_pkg.sv */
package absu_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CNTW       = AW + 1;
    localparam int PW         = 24;  // port coordinate width
    localparam int SCW        = 16;  // scale multiplier width
    localparam int CW         = 27;  // working centre width
    localparam int DW         = 28;  // difference width
    localparam int RW         = 29;  // radius and length width
    localparam int MW         = 30;  // multiplier operand width
    localparam int PRW        = 2 * MW;
    localparam int SUMW       = 58;  // sum of squares width
    localparam int DVN        = 60;  // divider numerator width
    localparam int DVD        = 30;  // divider denominator width
    localparam int FW         = 25;  // growth factor width
    localparam int START_RADIUS = 7;

    localparam logic [1:0] REG_CX    = 2'd0;
    localparam logic [1:0] REG_CY    = 2'd1;
    localparam logic [1:0] REG_CZ    = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(-v) : DW'(v);
        return m;
    endfunction

endpackage

/* design/absu_if.sv */
interface absu_pt_if;
    logic                             valid;
    logic                             ready;
    logic signed [absu_pkg::PW-1:0]   point_x;
    logic signed [absu_pkg::PW-1:0]   point_y;
    logic signed [absu_pkg::PW-1:0]   point_z;
    logic                             last_point;
    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface absu_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [absu_pkg::PW-1:0]   sphere_centre_x;
    logic signed [absu_pkg::PW-1:0]   sphere_centre_y;
    logic signed [absu_pkg::PW-1:0]   sphere_centre_z;
    logic        [absu_pkg::PW-1:0]   sphere_radius;
    logic        [absu_pkg::PW-1:0]   placed_radius;
    logic                             points_dropped;
    logic                             radius_saturated;
    modport source (output valid, sphere_centre_x, sphere_centre_y, sphere_centre_z,
                    sphere_radius, placed_radius, points_dropped, radius_saturated,
                    input ready);
    modport sink   (input valid, sphere_centre_x, sphere_centre_y, sphere_centre_z,
                    sphere_radius, placed_radius, points_dropped, radius_saturated,
                    output ready);
endinterface

interface absu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                index;
    logic [absu_pkg::PW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/absu_div.sv */
module absu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [absu_pkg::DVN-1:0]   i_num,
    input  logic [absu_pkg::DVD-1:0]   i_den,
    output logic                       o_busy,
    output logic [absu_pkg::DVN-1:0]   o_quot
);

    localparam int CNTB = $clog2(absu_pkg::DVN);

    logic                       r_busy;
    logic [CNTB-1:0]            r_cnt;
    logic [absu_pkg::DVN-1:0]   r_num;
    logic [absu_pkg::DVD-1:0]   r_rem;
    logic [absu_pkg::DVD-1:0]   r_den;
    logic [absu_pkg::DVD:0]     rem_sh;
    logic                       qbit;

    // One quotient bit per cycle; quotient bits shift in as numerator bits leave.
    assign rem_sh = {r_rem, r_num[absu_pkg::DVN-1]};
    assign qbit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTB'(absu_pkg::DVN - 1);
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= qbit ? absu_pkg::DVD'(rem_sh - {1'b0, r_den})
                          : absu_pkg::DVD'(rem_sh);
            r_num <= {r_num[absu_pkg::DVN-2:0], qbit};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

/* design/absu_sqrt.sv */
module absu_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [absu_pkg::SUMW-1:0]   i_rad,
    output logic                        o_busy,
    output logic [absu_pkg::RW-1:0]     o_root
);

    localparam int STEPS = absu_pkg::SUMW / 2;
    localparam int CNTB  = $clog2(STEPS);
    localparam int RMW   = absu_pkg::RW + 2;

    logic                        r_busy;
    logic [CNTB-1:0]             r_cnt;
    logic [absu_pkg::SUMW-1:0]   r_rad;
    logic [RMW-1:0]              r_rem;
    logic [absu_pkg::RW-1:0]     r_root;
    logic [RMW+1:0]              rem_sh;
    logic [RMW+1:0]              trial;
    logic                        take;

    // Two radicand bits per cycle give one root bit.
    assign rem_sh = {r_rem, r_rad[absu_pkg::SUMW-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTB'(STEPS - 1);
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
            r_root <= {r_root[absu_pkg::RW-2:0], take};
            r_rad  <= {r_rad[absu_pkg::SUMW-3:0], 2'b00};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

/* design/approximate_bounding_sphere_unit.sv */
// Point words are taken only while idle; a word without the last flag gives no result.
// A last word starts the fit: three passes over the N stored points, where each point
// outside the sphere takes a growth step in the first two passes and a Ritter step in
// the third, using the serial divider and the square root; a placement step finishes.
// Point words are taken again as soon as the result sits in the output register.
// Synchronous reset clears state, counts, flags and config; the point store is not cleared.
module approximate_bounding_sphere_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    absu_pt_if.sink     i_pt,
    absu_cfg_if.sink    i_cfg,
    absu_res_if.source  o_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_RD, S_INIT, S_RD, S_PT, S_SQ, S_SQACC, S_SQRT, S_CHK,
        S_G_DIV1, S_G_Q, S_G_F, S_G_RR, S_G_DIV2, S_G_MUL, S_G_UPD,
        S_R_MUL, S_R_DIV, S_R_WAIT, S_NEXT, S_FIN, S_PL_MUL, S_PL, S_HOLD
    } t_state;

    localparam int PW   = absu_pkg::PW;
    localparam int CW   = absu_pkg::CW;
    localparam int DW   = absu_pkg::DW;
    localparam int RW   = absu_pkg::RW;
    localparam int MW   = absu_pkg::MW;
    localparam int PRW  = absu_pkg::PRW;
    localparam int FW   = absu_pkg::FW;
    localparam int AW   = absu_pkg::AW;
    localparam int CNTW = absu_pkg::CNTW;

    t_state                     r_state;
    logic [3*PW-1:0]            mem [absu_pkg::MAX_POINTS];
    logic [3*PW-1:0]            r_rdata;
    logic [CNTW-1:0]            r_count;
    logic                       r_ovf;
    logic signed [PW-1:0]       r_want [3];
    logic [absu_pkg::SCW-1:0]   r_scale;

    logic signed [CW-1:0]       r_c [3];
    logic signed [DW-1:0]       r_d [3];
    logic [RW-1:0]              r_r;
    logic [RW-1:0]              r_len;
    logic [FW-1:0]              r_f;
    logic [1:0]                 r_pass;
    logic [1:0]                 r_k;
    logic [AW-1:0]              r_i;
    logic [absu_pkg::SUMW-1:0]  r_sum;
    logic                       r_final;
    logic [PRW-1:0]             r_prod;
    logic [PW-1:0]              r_placed;
    logic                       r_sat;

    logic                       r_ov_valid;
    logic signed [PW-1:0]       r_ocx, r_ocy, r_ocz;
    logic [PW-1:0]              r_orad, r_oplaced;
    logic                       r_odrop, r_osat;

    logic [MW-1:0]              m_a, m_b;
    logic                       div_start, sq_start, div_busy, sq_busy;
    logic [absu_pkg::DVN-1:0]   div_num, div_quot;
    logic [absu_pkg::DVD-1:0]   div_den;
    logic [RW-1:0]              sq_root;
    logic                       pt_acc, cfg_acc, out_free;
    logic [CNTW-1:0]            last_cnt;
    logic [DW-1:0]              dmag;
    logic signed [CW-1:0]       c_step;
    logic [PRW-1:0]             g_round;
    logic [RW:0]                rsum;
    logic [MW-1:0]              total;
    logic [PRW-1:0]             pl_full;

    assign pt_acc    = i_pt.valid && i_pt.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_pt.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free  = !r_ov_valid || o_res.ready;
    assign last_cnt  = r_count - 1'b1;
    assign dmag      = absu_pkg::mag(r_d[r_k]);
    assign g_round   = r_prod + (PRW'(1) << 24);
    assign rsum      = {1'b0, r_r} + {1'b0, r_len};
    assign total     = MW'(rsum);
    assign pl_full   = r_prod + PRW'(128);

    // Rounded growth step, sign restored from the difference.
    always_comb begin
        c_step = CW'(g_round[PRW-1:25]);
        if (r_d[r_k][DW-1]) begin
            c_step = -c_step;
        end
    end

    // Shared multiplier, registered product.
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_SQ: begin
                m_a = MW'(dmag);
                m_b = MW'(dmag);
            end
            S_G_Q: begin
                m_a = MW'(div_quot);
                m_b = MW'(div_quot);
            end
            S_G_F: begin
                m_a = MW'(r_r);
                m_b = MW'(r_r);
            end
            S_G_MUL: begin
                m_a = MW'(dmag);
                m_b = MW'(r_f);
            end
            S_R_MUL: begin
                m_a = MW'(dmag);
                m_b = MW'(r_len - r_r);
            end
            S_PL_MUL: begin
                m_a = total;
                m_b = MW'(r_scale);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = absu_pkg::DVD'(r_len);
        unique case (r_state)
            S_CHK: begin
                div_start = (r_len > r_r) && (r_pass != 2'd2);
                div_num   = absu_pkg::DVN'(r_r) << 24;
            end
            S_G_RR: begin
                div_start = 1'b1;
                div_num   = r_prod;
            end
            S_R_DIV: begin
                div_start = 1'b1;
                div_num   = r_prod + absu_pkg::DVN'(r_len >> 1);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sq_start = (r_state == S_SQACC) && (r_k == 2'd2);

    absu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    absu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_sum + absu_pkg::SUMW'(r_prod)),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // Point store.
    always_ff @(posedge i_clk) begin
        if (pt_acc && (r_count < CNTW'(absu_pkg::MAX_POINTS))) begin
            mem[r_count[AW-1:0]] <= {i_pt.point_z, i_pt.point_y, i_pt.point_x};
        end
        r_rdata <= mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_want[0]  <= '0;
            r_want[1]  <= '0;
            r_want[2]  <= '0;
            r_scale    <= absu_pkg::SCW'(256);
            r_ov_valid <= 1'b0;
            r_i        <= '0;
            r_k        <= '0;
            r_pass     <= '0;
            r_final    <= 1'b0;
        end else begin
            r_prod <= PRW'(m_a) * PRW'(m_b);
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    absu_pkg::REG_CX:    r_want[0] <= i_cfg.data;
                    absu_pkg::REG_CY:    r_want[1] <= i_cfg.data;
                    absu_pkg::REG_CZ:    r_want[2] <= i_cfg.data;
                    absu_pkg::REG_SCALE: r_scale   <= i_cfg.data[absu_pkg::SCW-1:0];
                endcase
            end
            // A result taken while the next one loads is replaced below instead.
            if (r_ov_valid && o_res.ready && (r_state != S_HOLD)) begin
                r_ov_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pt_acc) begin
                        if (r_count < CNTW'(absu_pkg::MAX_POINTS)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_pt.last_point) begin
                            r_i     <= '0;
                            r_state <= S_INIT_RD;
                        end
                    end
                end
                S_INIT_RD: r_state <= S_INIT;
                S_INIT: begin
                    r_c[0]  <= CW'(signed'(r_rdata[PW-1:0]));
                    r_c[1]  <= CW'(signed'(r_rdata[2*PW-1:PW]));
                    r_c[2]  <= CW'(signed'(r_rdata[3*PW-1:2*PW]));
                    r_r     <= RW'(absu_pkg::START_RADIUS);
                    r_pass  <= '0;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_PT;
                S_PT: begin
                    r_d[0]  <= DW'(signed'(r_rdata[PW-1:0])) - DW'(r_c[0]);
                    r_d[1]  <= DW'(signed'(r_rdata[2*PW-1:PW])) - DW'(r_c[1]);
                    r_d[2]  <= DW'(signed'(r_rdata[3*PW-1:2*PW])) - DW'(r_c[2]);
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_final <= 1'b0;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_SQACC;
                S_SQACC: begin
                    r_sum <= r_sum + absu_pkg::SUMW'(r_prod);
                    if (r_k == 2'd2) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: begin
                    if (!sq_busy) begin
                        r_len   <= sq_root;
                        r_state <= r_final ? S_PL_MUL : S_CHK;
                    end
                end
                S_CHK: begin
                    r_k <= '0;
                    if (r_len <= r_r) begin
                        r_state <= S_NEXT;
                    end else if (r_pass != 2'd2) begin
                        r_state <= S_G_DIV1;
                    end else begin
                        r_r     <= RW'(rsum >> 1);
                        r_state <= S_R_MUL;
                    end
                end
                S_G_DIV1: begin
                    if (!div_busy) begin
                        r_state <= S_G_Q;
                    end
                end
                S_G_Q: r_state <= S_G_F;
                S_G_F: begin
                    r_f     <= FW'((PRW'(1) << 24) - (r_prod >> 24));
                    r_state <= S_G_RR;
                end
                S_G_RR: r_state <= S_G_DIV2;
                S_G_DIV2: begin
                    if (!div_busy) begin
                        r_r     <= RW'(({1'b0, r_len} + (RW+1)'(div_quot)) >> 1);
                        r_state <= S_G_MUL;
                    end
                end
                S_G_MUL: r_state <= S_G_UPD;
                S_G_UPD: begin
                    r_c[r_k] <= r_c[r_k] + c_step;
                    if (r_k == 2'd2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_G_MUL;
                    end
                end
                S_R_MUL: r_state <= S_R_DIV;
                S_R_DIV: r_state <= S_R_WAIT;
                S_R_WAIT: begin
                    if (!div_busy) begin
                        if (r_d[r_k][DW-1]) begin
                            r_c[r_k] <= r_c[r_k] - CW'(div_quot);
                        end else begin
                            r_c[r_k] <= r_c[r_k] + CW'(div_quot);
                        end
                        if (r_k == 2'd2) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_R_MUL;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_i == last_cnt[AW-1:0]) begin
                        r_i <= '0;
                        if (r_pass == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_pass  <= r_pass + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    r_d[0]  <= DW'(r_want[0]) - DW'(r_c[0]);
                    r_d[1]  <= DW'(r_want[1]) - DW'(r_c[1]);
                    r_d[2]  <= DW'(r_want[2]) - DW'(r_c[2]);
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_final <= 1'b1;
                    r_state <= S_SQ;
                end
                S_PL_MUL: r_state <= S_PL;
                S_PL: begin
                    r_sat    <= (pl_full[PRW-1:PW+8] != '0);
                    r_placed <= (pl_full[PRW-1:PW+8] != '0) ? '1 : pl_full[PW+7:8];
                    r_state  <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_ov_valid <= 1'b1;
                        r_ocx      <= r_c[0][PW-1:0];
                        r_ocy      <= r_c[1][PW-1:0];
                        r_ocz      <= r_c[2][PW-1:0];
                        r_orad     <= (r_r > RW'({PW{1'b1}})) ? '1 : r_r[PW-1:0];
                        r_oplaced  <= r_placed;
                        r_odrop    <= r_ovf;
                        r_osat     <= r_sat;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_ov_valid;
    assign o_res.sphere_centre_x  = r_ocx;
    assign o_res.sphere_centre_y  = r_ocy;
    assign o_res.sphere_centre_z  = r_ocz;
    assign o_res.sphere_radius    = r_orad;
    assign o_res.placed_radius    = r_oplaced;
    assign o_res.points_dropped   = r_odrop;
    assign o_res.radius_saturated = r_osat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(absu_pkg::MAX_POINTS))
        else $error("point count beyond store capacity");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && out_free) |=> (r_count == '0 && !r_ovf && o_res.valid))
        else $error("result load did not close the point set");

endmodule

/* tb/sv/absu_sphere_checker.sv */
`timescale 1ns / 100ps

module absu_sphere_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    absu_pt_if   pt,
    absu_cfg_if  cfg,
    absu_res_if  res,
    output int   o_errors,
    output int   o_pending,
    output int   o_fits
);

    localparam int PW           = absu_pkg::PW;
    localparam int SCW          = absu_pkg::SCW;
    localparam int MAX_POINTS   = absu_pkg::MAX_POINTS;
    localparam int START_RADIUS = absu_pkg::START_RADIUS;

    typedef struct packed {
        logic [PW-1:0] cx;
        logic [PW-1:0] cy;
        logic [PW-1:0] cz;
        logic [PW-1:0] radius;
        logic [PW-1:0] placed;
        logic          dropped;
        logic          saturated;
    } t_sphere;

    localparam longint unsigned MAX24 = 64'hFF_FFFF;

    t_sphere         spheres_due[$];
    longint          point_mem[MAX_POINTS][3];
    int unsigned     stored_points;
    bit              overflow;
    longint          want_centre[3];
    longint unsigned scale;

    assign o_pending = spheres_due.size();

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned length3(input longint d[3]);
        longint unsigned sum;
        longint unsigned m;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            m = (d[k] < 0) ? -d[k] : d[k];
            sum += m * m;
        end
        return isqrt(sum);
    endfunction

    // Rounds d * num / den to nearest, ties away from zero.
    function automatic longint scaled_round(longint d, longint unsigned num,
                                            longint unsigned den);
        longint unsigned m;
        longint unsigned q;
        m = (d < 0) ? -d : d;
        q = (m * num + den / 2) / den;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_sphere fit_sphere();
        longint          c[3];
        longint          d[3];
        longint unsigned r;
        longint unsigned len;
        longint unsigned q;
        longint unsigned f;
        longint unsigned total;
        longint unsigned placed;
        t_sphere         s;
        r = START_RADIUS;
        for (int k = 0; k < 3; k++)
            c[k] = point_mem[0][k];
        for (int pass = 0; pass < 3; pass++) begin
            for (int i = 0; i < stored_points; i++) begin
                for (int k = 0; k < 3; k++)
                    d[k] = point_mem[i][k] - c[k];
                len = length3(d);
                if (len > r) begin
                    if (pass < 2) begin
                        q = (r << 24) / len;
                        f = (64'd1 << 24) - ((q * q) >> 24);
                        r = (len + (r * r) / len) / 2;
                        for (int k = 0; k < 3; k++)
                            c[k] += scaled_round(d[k], f, 64'd1 << 25);
                    end else begin
                        r = (r + len) / 2;
                        for (int k = 0; k < 3; k++)
                            c[k] += scaled_round(d[k], len - r, len);
                    end
                end
            end
        end
        for (int k = 0; k < 3; k++)
            d[k] = want_centre[k] - c[k];
        total = r + length3(d);
        placed = (total * scale + 128) >> 8;
        s.cx = c[0][PW-1:0];
        s.cy = c[1][PW-1:0];
        s.cz = c[2][PW-1:0];
        s.radius = (r > MAX24) ? MAX24[PW-1:0] : r[PW-1:0];
        s.saturated = placed > MAX24;
        s.placed = s.saturated ? MAX24[PW-1:0] : placed[PW-1:0];
        s.dropped = overflow;
        return s;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sphere s;
        if (!i_rst_n) begin
            spheres_due.delete();
            stored_points = 0;
            overflow = 0;
            want_centre = '{0, 0, 0};
            scale = 256;
            o_errors = 0;
            o_fits = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    absu_pkg::REG_CX:    want_centre[0] = $signed(cfg.data);
                    absu_pkg::REG_CY:    want_centre[1] = $signed(cfg.data);
                    absu_pkg::REG_CZ:    want_centre[2] = $signed(cfg.data);
                    absu_pkg::REG_SCALE: scale = cfg.data[SCW-1:0];
                endcase
            end
            if (pt.valid && pt.ready) begin
                if (stored_points < MAX_POINTS) begin
                    point_mem[stored_points][0] = pt.point_x;
                    point_mem[stored_points][1] = pt.point_y;
                    point_mem[stored_points][2] = pt.point_z;
                    stored_points++;
                end else begin
                    overflow = 1;
                end
                if (pt.last_point) begin
                    spheres_due.push_back(fit_sphere());
                    stored_points = 0;
                    overflow = 0;
                end
            end
            if (res.valid && res.ready) begin
                if (spheres_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got radius 0x%0h",
                             $time, res.sphere_radius);
                    o_errors++;
                end else begin
                    s = spheres_due.pop_front();
                    o_fits++;
                    check_field("sphere_centre_x", s.cx, res.sphere_centre_x[PW-1:0]);
                    check_field("sphere_centre_y", s.cy, res.sphere_centre_y[PW-1:0]);
                    check_field("sphere_centre_z", s.cz, res.sphere_centre_z[PW-1:0]);
                    check_field("sphere_radius", s.radius, res.sphere_radius);
                    check_field("placed_radius", s.placed, res.placed_radius);
                    check_field("points_dropped", s.dropped, res.points_dropped);
                    check_field("radius_saturated", s.saturated, res.radius_saturated);
                end
            end
        end
    end

endmodule

/* tb/sv/approximate_bounding_sphere_unit_tb.sv */
`timescale 1ns / 100ps

module approximate_bounding_sphere_unit_tb;

    localparam int PW         = absu_pkg::PW;
    localparam int SCW        = absu_pkg::SCW;
    localparam int MAX_POINTS = absu_pkg::MAX_POINTS;
    localparam int IDLE_LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   fits;
    int   points_sent;
    int   idle_cycles;
    int   hold_cycles;
    bit   quiet;

    absu_pt_if  pt ();
    absu_cfg_if cfg ();
    absu_res_if res ();

    approximate_bounding_sphere_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    absu_sphere_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pt        (pt),
        .cfg       (cfg),
        .res       (res),
        .o_errors  (errors),
        .o_pending (pending),
        .o_fits    (fits)
    );

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n = 0;
        pt.valid = 0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        pt.last_point = 0;
        cfg.valid = 0;
        cfg.index = absu_pkg::REG_CX;
        cfg.data = '0;
        res.ready = 0;
        hold_cycles = 0;
        quiet = 0;
        points_sent = 0;
    end

    // Cycles without any accepted word; a hang ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt.valid && pt.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Result side: random stalls, plus one long hold when requested.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                res.ready <= 0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                res.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            res.ready <= 1;
            do @(posedge i_clk); while (!(res.valid && res.ready));
        end
    end

    task automatic send_point(logic [PW-1:0] x, logic [PW-1:0] y, logic [PW-1:0] z,
                              bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            pt.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        pt.valid <= 1;
        pt.point_x <= x;
        pt.point_y <= y;
        pt.point_z <= z;
        pt.last_point <= last;
        do @(posedge i_clk); while (!(pt.valid && pt.ready));
        points_sent++;
    endtask

    task automatic release_points();
        pt.valid <= 0;
        @(posedge i_clk);
    endtask

    // Waits until every expected sphere is back, then lets the block go quiet.
    task automatic drain();
        release_points();
        while (pending != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [PW-1:0] value);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_placement(logic [PW-1:0] x, logic [PW-1:0] y, logic [PW-1:0] z,
                                 logic [SCW-1:0] mult);
        write_reg(absu_pkg::REG_CX, x);
        write_reg(absu_pkg::REG_CY, y);
        write_reg(absu_pkg::REG_CZ, z);
        write_reg(absu_pkg::REG_SCALE, PW'(mult));
    endtask

    function automatic logic [PW-1:0] any_coord();
        return PW'($urandom_range(0, 24'hFF_FFFF));
    endfunction

    // Point sets: clustered around a random spot, full range, or on the extremes.
    task automatic send_set(int count, int shape);
        logic [PW-1:0] base[3];
        logic [PW-1:0] p[3];
        int spread;
        for (int k = 0; k < 3; k++)
            base[k] = any_coord();
        spread = 1 << $urandom_range(4, 20);
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 3; k++) begin
                case (shape)
                    0: p[k] = base[k] + PW'($urandom_range(0, spread)) - PW'(spread / 2);
                    1: p[k] = any_coord();
                    default: p[k] = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
                endcase
            end
            send_point(p[0], p[1], p[2], i == count - 1);
        end
    endtask

    initial begin
        int random_start;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed sets at reset placement.
        send_point(24'h00_0000, 24'h00_0000, 24'h00_0000, 1);
        send_point(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 0);
        send_point(24'h80_0000, 24'h80_0000, 24'h80_0000, 1);
        send_point(24'h7F_FFFF, 24'h80_0000, 24'h00_0001, 0);
        send_point(24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF, 0);
        send_point(24'h00_0000, 24'h00_0000, 24'h80_0000, 1);
        send_point(24'h00_1234, 24'h00_1234, 24'h00_1234, 0);
        send_point(24'h00_1234, 24'h00_1234, 24'h00_1234, 1);
        send_set(8, 2);
        drain();

        set_placement(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 16'hFFFF);
        send_set(2, 2);
        send_set(5, 1);
        send_set(1, 0);
        drain();

        set_placement(24'h80_0000, 24'h80_0000, 24'h80_0000, 16'h0000);
        send_set(6, 2);
        send_set(3, 1);
        drain();

        // A full store and more: the extra points, the last among them, are dropped.
        quiet = 1;
        set_placement(24'h00_0000, 24'h00_0000, 24'h00_0000, 16'h0100);
        send_point(24'h01_0000, 24'h01_0000, 24'h01_0000, 0);
        send_point(24'hFF_0000, 24'hFF_0000, 24'hFF_0000, 0);
        for (int i = 2; i < MAX_POINTS + 3; i++)
            send_point(PW'($urandom_range(0, 24'h1_0000)) - 24'h8000,
                       PW'($urandom_range(0, 24'h1_0000)) - 24'h8000,
                       PW'($urandom_range(0, 24'h1_0000)) - 24'h8000,
                       i == MAX_POINTS + 2);
        send_set(3, 0);
        drain();

        // Stall the result side long enough for words to back up into the input.
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++)
            send_set($urandom_range(1, 4), $urandom_range(0, 1));
        quiet = 0;
        drain();

        random_start = points_sent;
        while (points_sent - random_start < 450) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                set_placement(any_coord(), any_coord(), any_coord(),
                              SCW'($urandom_range(0, 16'hFFFF)));
                quiet = $urandom_range(0, 3) == 0;
            end
            if ($urandom_range(0, 15) == 0)
                send_set($urandom_range(20, 40), $urandom_range(0, 2));
            else
                send_set($urandom_range(1, 8), $urandom_range(0, 9) < 6 ? 0 :
                         $urandom_range(1, 2));
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d points and checked %0d fitted spheres across several placements,",
                 points_sent, fits);
        $display("including a store overflow and a long result-side stall.");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
